FILE: rtl/core/sorted_timer_queue_macros.svh
// assertion macros shared by the sorted timer queue rtl
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// invariant checked at every clock edge outside reset
`define STQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sorted_timer_queue: invariant violated");

// property that must hold in the cycle after a trigger
`define STQ_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error("sorted_timer_queue: follow-up check failed");

`endif

FILE: rtl/core/stq_pkg.sv
// shared constants and codes of the sorted timer queue
package stq_pkg;

    // default number of timer slots
    localparam int DEF_TIMER_SLOTS = 8;

    // field widths
    localparam int FUNC_W     = 3;
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 32;
    localparam int KIND_W     = 2;
    localparam int EN_W       = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // most expirations reported by one tick
    localparam int MAX_POPS = 8;
    localparam int POP_W    = $clog2(MAX_POPS + 1);

    // operation codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 3'd0,
        FUNC_START_AT = 3'd1,
        FUNC_START_IN = 3'd2,
        FUNC_STOP     = 3'd3,
        FUNC_READ     = 3'd4
    } t_func;

    // result kinds carried in the output tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRED  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_COUNT    = 2'd3
    } t_kind;

endpackage

FILE: rtl/core/stq_ram.sv
// generic single-write single-read ram with registered read data
module stq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/sorted_timer_queue.sv
// Sorted timer queue: a 32-bit tick count and a queue of up to TIMER_SLOTS timer slots kept
// in expiry order (wrap-aware signed compare), held as a circular list of {slot, expiry}
// entries in one ram with a registered read. One item is worked at a time; the
// input is ready only when the previous item is finished, and a result register on the
// output side lets the next item start while the last result waits. Every list step is a
// ram read followed by a check or a write-back. A tick pops due entries from the head; a
// start scans from the head to the first later expiry and moves the later entries one
// place back; a stop scans to its slot and moves the entries behind it one place forward.
// The queue needs no clearing pass after reset. Output stalls lengthen the work of an item.
`include "sorted_timer_queue_macros.svh"

module sorted_timer_queue #(
    parameter int TIMER_SLOTS = stq_pkg::DEF_TIMER_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slot enable register write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stq_pkg::EN_W-1:0]         i_cfg_data,
    // input items
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [stq_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,   // slot[2:0], value[34:3]
    input  logic [stq_pkg::FUNC_W-1:0]       i_s_axis_tuser,   // func[2:0]
    // result items
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [stq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,   // slot_out[2:0], count[34:3]
    output logic [stq_pkg::KIND_W-1:0]       o_m_axis_tuser,   // kind[1:0]
    output logic                             o_m_axis_tlast
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LEN_W = $clog2(TIMER_SLOTS + 1);
    localparam int CW    = stq_pkg::CNT_W;
    localparam int SW    = stq_pkg::SLOT_W;
    localparam int ENT_W = CW + IDX_W;
    localparam int PAD_W = stq_pkg::OUT_DATA_W - CW - SW;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_TK_RD    = 8'b0000_0010,
        S_TK_CHK   = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CHK = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_WR = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } t_state;

    // control state
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_now, n_now;
    logic [stq_pkg::EN_W-1:0]    r_en, n_en;
    logic [IDX_W-1:0]            r_head, n_head;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [TIMER_SLOTS-1:0]      r_queued, n_queued;
    logic                        r_resp_v, n_resp_v;
    logic                        r_o_v, n_o_v;

    // working registers of the current item
    logic                        r_is_stop, n_is_stop;
    logic [SW-1:0]               r_slot, n_slot;
    logic [CW-1:0]               r_exp, n_exp;
    logic [LEN_W-1:0]            r_i, n_i;
    logic [LEN_W-1:0]            r_pos, n_pos;
    logic [stq_pkg::POP_W-1:0]   r_npop, n_npop;
    stq_pkg::t_kind              r_resp_kind, n_resp_kind;
    logic [SW-1:0]               r_resp_slot, n_resp_slot;
    logic [CW-1:0]               r_resp_count, n_resp_count;
    stq_pkg::t_kind              r_o_kind, n_o_kind;
    logic [SW-1:0]               r_o_slot, n_o_slot;
    logic [CW-1:0]               r_o_count, n_o_count;
    logic                        r_o_last, n_o_last;

    // ram ports
    logic                        w_rd_en;
    logic [IDX_W-1:0]            w_rd_addr;
    logic [ENT_W-1:0]            w_rd_data;
    logic                        w_wr_en;
    logic [IDX_W-1:0]            w_wr_addr;
    logic [ENT_W-1:0]            w_wr_data;

    // input fields and helpers
    logic [stq_pkg::FUNC_W-1:0]  w_func;
    logic [SW-1:0]               w_slot;
    logic [CW-1:0]               w_value;
    logic [IDX_W-1:0]            w_sidx;
    logic [IDX_W-1:0]            w_r_sidx;
    logic                        w_slot_ok;
    logic                        w_in_xfer;
    logic                        w_out_free;
    logic [CW-1:0]               w_rd_exp;
    logic [IDX_W-1:0]            w_rd_slot;
    logic [CW-1:0]               w_due_diff;
    logic [CW-1:0]               w_ins_diff;
    logic [IDX_W-1:0]            w_head_inc;

    // position in the circular list to ram address
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                input logic [LEN_W-1:0] ofs);
        logic [LEN_W:0] s;
        s = (LEN_W+1)'(head) + (LEN_W+1)'(ofs);
        if (s >= (LEN_W+1)'(TIMER_SLOTS)) begin
            s = s - (LEN_W+1)'(TIMER_SLOTS);
        end
        return IDX_W'(s);
    endfunction

    stq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TIMER_SLOTS)
    ) u_list_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // field unpacking and small helpers
    assign w_func     = i_s_axis_tuser;
    assign w_slot     = i_s_axis_tdata[SW-1:0];
    assign w_value    = i_s_axis_tdata[SW+CW-1:SW];
    assign w_sidx     = IDX_W'(w_slot);
    assign w_r_sidx   = IDX_W'(r_slot);
    assign w_slot_ok  = 32'(w_slot) < 32'(TIMER_SLOTS);
    assign w_in_xfer  = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_o_v || i_m_axis_tready;
    assign w_rd_exp   = w_rd_data[CW-1:0];
    assign w_rd_slot  = w_rd_data[ENT_W-1:CW];
    assign w_due_diff = r_now - w_rd_exp;
    assign w_ins_diff = r_exp - w_rd_exp;
    assign w_head_inc = (r_head == IDX_W'(TIMER_SLOTS - 1)) ? '0 : r_head + 1'b1;

    // sequencer: one list step per read/check pair, accesses never overlap
    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_en         = r_en;
        n_head       = r_head;
        n_len        = r_len;
        n_queued     = r_queued;
        n_resp_v     = r_resp_v;
        n_is_stop    = r_is_stop;
        n_slot       = r_slot;
        n_exp        = r_exp;
        n_i          = r_i;
        n_pos        = r_pos;
        n_npop       = r_npop;
        n_resp_kind  = r_resp_kind;
        n_resp_slot  = r_resp_slot;
        n_resp_count = r_resp_count;
        n_o_v        = r_o_v && !i_m_axis_tready;
        n_o_kind     = r_o_kind;
        n_o_slot     = r_o_slot;
        n_o_count    = r_o_count;
        n_o_last     = r_o_last;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_head;
        w_wr_data    = {w_r_sidx, r_exp};

        // slot enable register write
        if (i_cfg_valid) begin
            n_en = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_slot      = w_slot;
                    n_resp_slot = w_slot;
                    n_i         = '0;
                    case (w_func)
                        stq_pkg::FUNC_TICK: begin
                            n_now    = r_now + 1'b1;
                            n_npop   = '0;
                            n_resp_v = 1'b0;
                            n_state  = S_TK_RD;
                        end
                        stq_pkg::FUNC_START_AT, stq_pkg::FUNC_START_IN: begin
                            n_exp = (w_func == stq_pkg::FUNC_START_AT) ? w_value
                                                                       : w_value + r_now;
                            n_resp_v  = 1'b1;
                            n_is_stop = 1'b0;
                            n_state   = S_RESP;
                            if (!w_slot_ok || r_queued[w_sidx] || !r_en[w_slot]) begin
                                n_resp_kind  = stq_pkg::KIND_REJECTED;
                                n_resp_count = '0;
                            end else begin
                                n_resp_kind  = stq_pkg::KIND_ACCEPTED;
                                n_resp_count = n_exp;
                                // a full list takes no insert
                                if (r_len != LEN_W'(TIMER_SLOTS)) begin
                                    n_state = S_SCAN_RD;
                                end
                            end
                        end
                        stq_pkg::FUNC_STOP: begin
                            n_resp_v     = 1'b1;
                            n_is_stop    = 1'b1;
                            n_resp_count = '0;
                            n_state      = S_RESP;
                            if (!w_slot_ok) begin
                                n_resp_kind = stq_pkg::KIND_REJECTED;
                            end else begin
                                n_resp_kind = stq_pkg::KIND_ACCEPTED;
                                if (r_queued[w_sidx]) begin
                                    n_state = S_SCAN_RD;
                                end
                            end
                        end
                        stq_pkg::FUNC_READ: begin
                            n_resp_v     = 1'b1;
                            n_resp_kind  = stq_pkg::KIND_COUNT;
                            n_resp_slot  = '0;
                            n_resp_count = r_now;
                            n_state      = S_RESP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // tick: fetch the head entry
            S_TK_RD: begin
                if (r_len == '0 || r_npop == stq_pkg::POP_W'(stq_pkg::MAX_POPS)) begin
                    n_state = r_resp_v ? S_RESP : S_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_head;
                    n_state   = S_TK_CHK;
                end
            end

            // tick: pop the head if due, holding the newest expiry back to mark the last
            S_TK_CHK: begin
                if (w_due_diff[CW-1]) begin
                    n_state = r_resp_v ? S_RESP : S_IDLE;
                end else if (!r_resp_v || w_out_free) begin
                    if (r_resp_v) begin
                        n_o_v     = 1'b1;
                        n_o_kind  = r_resp_kind;
                        n_o_slot  = r_resp_slot;
                        n_o_count = r_resp_count;
                        n_o_last  = 1'b0;
                    end
                    n_resp_v               = 1'b1;
                    n_resp_kind            = stq_pkg::KIND_EXPIRED;
                    n_resp_slot            = SW'(w_rd_slot);
                    n_resp_count           = w_rd_exp;
                    n_queued[w_rd_slot]    = 1'b0;
                    n_head                 = w_head_inc;
                    n_len                  = r_len - 1'b1;
                    n_npop                 = r_npop + 1'b1;
                    n_state                = S_TK_RD;
                end
            end

            // scan the list from the head
            S_SCAN_RD: begin
                if (r_i == r_len) begin
                    if (r_is_stop) begin
                        n_queued[w_r_sidx] = 1'b0;
                        n_state            = S_RESP;
                    end else begin
                        n_pos   = r_len;
                        n_i     = r_len;
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = f_phys(r_head, r_i);
                    n_state   = S_SCAN_CHK;
                end
            end

            // insert stops at the first later expiry, stop at the matching slot
            S_SCAN_CHK: begin
                if (r_is_stop) begin
                    if (w_rd_slot == w_r_sidx) begin
                        n_pos   = r_i;
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    if (w_ins_diff[CW-1]) begin
                        n_pos   = r_i;
                        n_i     = r_len;
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end

            // move one entry, or finish the insert or removal
            S_SHIFT_RD: begin
                if (r_is_stop) begin
                    if ((LEN_W+1)'(r_i) + 1'b1 >= (LEN_W+1)'(r_len)) begin
                        n_len              = r_len - 1'b1;
                        n_queued[w_r_sidx] = 1'b0;
                        n_state            = S_RESP;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = f_phys(r_head, r_i + 1'b1);
                        n_state   = S_SHIFT_WR;
                    end
                end else begin
                    if (r_i == r_pos) begin
                        w_wr_en            = 1'b1;
                        w_wr_addr          = f_phys(r_head, r_pos);
                        w_wr_data          = {w_r_sidx, r_exp};
                        n_len              = r_len + 1'b1;
                        n_queued[w_r_sidx] = 1'b1;
                        n_state            = S_RESP;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = f_phys(r_head, r_i - 1'b1);
                        n_state   = S_SHIFT_WR;
                    end
                end
            end

            // write the fetched entry one place over
            S_SHIFT_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = f_phys(r_head, r_i);
                w_wr_data = w_rd_data;
                n_i       = r_is_stop ? r_i + 1'b1 : r_i - 1'b1;
                n_state   = S_SHIFT_RD;
            end

            // final result of the item
            S_RESP: begin
                if (w_out_free) begin
                    n_o_v     = 1'b1;
                    n_o_kind  = r_resp_kind;
                    n_o_slot  = r_resp_slot;
                    n_o_count = r_resp_count;
                    n_o_last  = 1'b1;
                    n_resp_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_en     <= '0;
            r_head   <= '0;
            r_len    <= '0;
            r_queued <= '0;
            r_resp_v <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_en     <= n_en;
            r_head   <= n_head;
            r_len    <= n_len;
            r_queued <= n_queued;
            r_resp_v <= n_resp_v;
            r_o_v    <= n_o_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_is_stop    <= n_is_stop;
        r_slot       <= n_slot;
        r_exp        <= n_exp;
        r_i          <= n_i;
        r_pos        <= n_pos;
        r_npop       <= n_npop;
        r_resp_kind  <= n_resp_kind;
        r_resp_slot  <= n_resp_slot;
        r_resp_count <= n_resp_count;
        r_o_kind     <= n_o_kind;
        r_o_slot     <= n_o_slot;
        r_o_count    <= n_o_count;
        r_o_last     <= n_o_last;
    end

    // ports
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_o_count, r_o_slot};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

    // checks
    `STQ_ASSERT_ALWAYS(a_len_bound, r_len <= LEN_W'(TIMER_SLOTS))
    `STQ_ASSERT_ALWAYS(a_flags_match_len, (r_state != S_IDLE) || ($countones(r_queued) == r_len))
    `STQ_ASSERT_NEXT(a_head_hold, (r_state == S_TK_CHK) && (n_state == S_TK_CHK), $stable(w_rd_data))

endmodule
